// File: rtl/partition_completion_tracker_defines.svh
// Assertion macros shared by the partition completion tracker.
`ifndef PARTITION_COMPLETION_TRACKER_DEFINES_SVH
`define PARTITION_COMPLETION_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pct_pkg.sv
// Shared types and constants of the partition completion tracker.
package pct_pkg;

  localparam int IDX_W       = 20;  // byte_index width
  localparam int PS_W        = 13;  // partition size register and counter width
  localparam int BT_W        = 21;  // byte_total register width
  localparam int PIDX_W      = 8;   // reported partition number width
  localparam int ST_W        = 2;   // status width
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 21;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ST_W-1:0] ST_COMPLETE = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_TOTAL     = 2'd1;

  localparam logic ACT_CLEAR = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // zero every counter
    logic zero_err;  // load the zero partition size result
    logic div_load;  // load the divider with the byte index
    logic div_step;  // one restoring divide step
    logic mem_read;  // read the counter, form the range product
    logic check;     // decide, update the counter, load the result
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ps_zero;
    logic has_result;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/pct_ctrl.sv
// Controller state machine of the partition completion tracker.
module pct_ctrl
  import pct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic action,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  localparam int CNT_W = $clog2(IDX_W + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] steps, steps_next;
  logic accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    steps_next = steps;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (sts.ps_zero) begin
            cmd.zero_err = 1'b1;
            state_next   = S_EMIT;
          end else begin
            cmd.div_load = 1'b1;
            steps_next   = CNT_W'(IDX_W);
            state_next   = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        steps_next   = steps - 1'b1;
        if (steps == CNT_W'(1)) state_next = S_RD;
      end
      S_RD: begin
        cmd.mem_read = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        cmd.check  = 1'b1;
        state_next = sts.has_result ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
    end
  end

endmodule

// File: rtl/pct_dp.sv
// Datapath of the partition completion tracker: registers, divider, counter store.
module pct_dp
  import pct_pkg::*;
#(
  parameter int MAX_PARTITIONS     = 256,
  parameter int MAX_PARTITION_SIZE = 4096,
  parameter int INDEX_BITS         = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IDX_W-1:0]       byte_index,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [ST_W-1:0]        m_tuser
);

  localparam int PART_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int PROD_W = PART_W + 1 + PS_W;
  localparam int CMP_W  = (PROD_W > BT_W) ? PROD_W : BT_W;
  localparam logic [IDX_W-1:0] IDX_MASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic [PS_W-1:0]   ps_reg, ps_eff;
  logic [BT_W-1:0]   bt_reg;
  logic [IDX_W-1:0]  quo, quo_next;
  logic [PS_W-1:0]   rem, rem_next;
  logic [PS_W:0]     rem_sh, rem_dif;
  logic [PART_W-1:0] addr;
  logic [PART_W:0]   part_inc;
  logic [PROD_W-1:0] prod;
  logic [PS_W-1:0]   mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] vld;
  logic [PS_W-1:0]   rd_cnt, cnt_cur, cnt_inc;
  logic              rd_vld;
  logic              out_range, over, done, upd;
  logic [PIDX_W-1:0] res_part;
  logic [ST_W-1:0]   res_st, res_st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps_reg <= PS_W'(1);
      bt_reg <= BT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PARTITION_SIZE: ps_reg <= cfg_data[PS_W-1:0];
        REG_BYTE_TOTAL:     bt_reg <= cfg_data[BT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(ps_reg) > 32'(MAX_PARTITION_SIZE)) ps_eff = PS_W'(MAX_PARTITION_SIZE);
    else ps_eff = ps_reg;
  end

  // Restoring divider, one quotient bit a cycle, dividend shifted out of quo.
  always_comb begin
    rem_sh  = {rem, quo[IDX_W-1]};
    rem_dif = rem_sh - {1'b0, ps_eff};
    if (rem_sh >= {1'b0, ps_eff}) begin
      rem_next = rem_dif[PS_W-1:0];
      quo_next = {quo[IDX_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[PS_W-1:0];
      quo_next = {quo[IDX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo <= byte_index & IDX_MASK;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign addr     = quo[PART_W-1:0];
  assign part_inc = {1'b0, addr} + (PART_W+1)'(1);

  // (partition + 1) * size must not pass byte_total for the partition to exist.
  always_ff @(posedge clk) begin
    if (cmd.mem_read) prod <= PROD_W'(part_inc) * PROD_W'(ps_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) rd_cnt <= mem[addr];
    if (cmd.check && upd) mem[addr] <= cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.mem_read) rd_vld <= vld[addr];
      if (cmd.clear) vld <= '0;
      else if (cmd.check && upd) vld[addr] <= 1'b1;
    end
  end

  assign cnt_cur   = rd_vld ? rd_cnt : '0;
  assign cnt_inc   = cnt_cur + PS_W'(1);
  assign out_range = (32'(quo) >= 32'(MAX_PARTITIONS)) || (CMP_W'(prod) > CMP_W'(bt_reg));
  assign over      = (cnt_cur >= ps_eff);
  assign done      = (cnt_inc == ps_eff);
  assign upd       = !out_range && !over;

  always_comb begin
    if (out_range) res_st_next = ST_RANGE;
    else if (over) res_st_next = ST_OVER;
    else res_st_next = ST_COMPLETE;
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_err) begin
      res_part <= '1;
      res_st   <= ST_RANGE;
    end else if (cmd.check) begin
      res_part <= quo[PIDX_W-1:0];
      res_st   <= res_st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= res_part;
      m_tuser <= res_st;
    end
  end

  assign sts.ps_zero    = (ps_reg == '0);
  assign sts.has_result = out_range || over || done;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

// File: rtl/partition_completion_tracker.sv
// Top level of the partition completion tracker.
//
//  Channel  Direction  Beat contents
//  s_*      in         tdata: byte_index [19:0], zero pad; tuser: action
//  m_*      out        tdata: part_id [7:0]; tuser: status
//  cfg_*    in         cfg_index: register number; cfg_data: register value
//
// A byte beat that yields no result passes from acceptance through the
// restoring divider (one quotient bit per cycle), a read of the counter store
// that also forms the range product, and an update of the counter, and then
// returns to idle where the next beat is taken.
// A byte beat that yields a result then also hands it to the output register;
// with a zero partition size a byte beat goes straight to that hand-over.
// A clear beat zeroes the counters at once through their valid bits; reset
// does the same, so no clearing pass is needed.
// A result waits in the output register while the next beat is accepted; only a
// second result stalls the controller until m_tready frees that register.
`include "partition_completion_tracker_defines.svh"

module partition_completion_tracker
  import pct_pkg::*;
#(
  parameter int MAX_PARTITIONS     = 256,
  parameter int MAX_PARTITION_SIZE = 4096,
  parameter int INDEX_BITS         = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,    // [19:0] byte_index, [23:20] zero
  input  logic                   s_tuser,    // [0] action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,    // [7:0] part_id
  output logic [ST_W-1:0]        m_tuser,    // [1:0] status
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic clear_beat;
  logic byte_beat;
  logic status_known;

  // Configuration is always taken; the registers live in the datapath.
  assign cfg_ready = 1'b1;

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .action   (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pct_dp #(
    .MAX_PARTITIONS     (MAX_PARTITIONS),
    .MAX_PARTITION_SIZE (MAX_PARTITION_SIZE),
    .INDEX_BITS         (INDEX_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .byte_index (s_tdata[IDX_W-1:0]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  assign clear_beat   = s_tvalid && s_tready && (s_tuser == ACT_CLEAR);
  assign byte_beat    = s_tvalid && s_tready && (s_tuser != ACT_CLEAR);
  assign status_known = (m_tuser == ST_COMPLETE) || (m_tuser == ST_RANGE) ||
                        (m_tuser == ST_OVER);

  // A clear beat finishes in its own cycle and leaves the block ready again.
  `PCT_ASSERT_NEXT(a_clear_one_cycle, clear_beat, s_tready, "clear beat kept the block busy")
  // A byte beat always keeps the block busy for at least the following cycle.
  `PCT_ASSERT_NEXT(a_byte_busy, byte_beat, !s_tready, "byte beat did not occupy the block")
  // Only the three defined status codes ever leave the block.
  `PCT_ASSERT_SAME(a_status_code, m_tvalid, status_known, "undefined status code on output")

endmodule
